// ===== hw/rtl/mcrf_pkg.sv =====
// Shared types, codes, constants and microcode for the Muller cubic root finder.
// Used by mcrf_alu and muller_cubic_root_finder; depends on nothing else.
`default_nettype none

package mcrf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_SHIFT  = 32 - FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] first_guess;
        logic signed [31:0] second_guess;
        logic signed [31:0] third_guess;
    } item_t;

    typedef struct packed {
        logic signed [31:0] root;
        logic [1:0]         status;
        logic [8:0]         iterations_used;
    } result_t;

    localparam logic [1:0] STAT_CONV  = 2'd0;
    localparam logic [1:0] STAT_LIMIT = 2'd1;
    localparam logic [1:0] STAT_DISC  = 2'd2;
    localparam logic [1:0] STAT_FAULT = 2'd3;

    localparam logic [7:0] LIMIT_RESET = 8'd50;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT, OP_QSEL, OP_MOV
    } alu_op_t;

    typedef enum logic [2:0] {
        CHK_NONE, CHK_DEN, CHK_DISC, CHK_Q, CHK_RVAL, CHK_MVAL, CHK_FIN
    } chk_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_FETCH, ST_ISSUE, ST_WAIT, ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic fault;
    } alu_rsp_t;

    typedef struct packed {
        alu_op_t    op;
        logic [4:0] dst;
        logic [4:0] srca;
        logic [4:0] srcb;
        chk_t       chk;
    } uop_t;

    // Register file slots; codes with bit 4 set pick a constant
    localparam logic [4:0] R_X0 = 5'd0,  R_X1 = 5'd1,  R_X2 = 5'd2;
    localparam logic [4:0] R_F1 = 5'd3,  R_F2 = 5'd4,  R_F3 = 5'd5;
    localparam logic [4:0] R_H1 = 5'd6,  R_H2 = 5'd7,  R_D1 = 5'd8;
    localparam logic [4:0] R_D2 = 5'd9,  R_DEN = 5'd10, R_A1 = 5'd11;
    localparam logic [4:0] R_A2 = 5'd12, R_T = 5'd13,  R_U = 5'd14;
    localparam logic [4:0] R_R  = 5'd15;
    localparam logic [4:0] K_2  = 5'd16, K_10 = 5'd17, K_20 = 5'd18;
    localparam logic [4:0] K_4  = 5'd19, K_M2 = 5'd20, K_100 = 5'd21;

    localparam logic [5:0] LAST_PC = 6'd51;

    function automatic logic signed [63:0] const_val(input logic [4:0] code);
        logic signed [63:0] v;
        case (code)
            K_2:     v = 64'sh0000_0002_0000_0000;
            K_10:    v = 64'sh0000_000A_0000_0000;
            K_20:    v = 64'sh0000_0014_0000_0000;
            K_4:     v = 64'sh0000_0004_0000_0000;
            K_M2:    v = 64'shFFFF_FFFE_0000_0000;
            K_100:   v = 64'sh0000_0064_0000_0000;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [63:0] to_q32(input logic signed [31:0] g);
        return {{FRAC_BITS{g[31]}}, g, {IN_SHIFT{1'b0}}};
    endfunction

    function automatic uop_t ucode(input logic [5:0] pc);
        uop_t u;
        case (pc)
            // p(x0) -> f1
            6'd0:  u = '{OP_MUL, R_T,  R_X0, R_X0, CHK_NONE};
            6'd1:  u = '{OP_MUL, R_U,  R_T,  R_X0, CHK_NONE};
            6'd2:  u = '{OP_MUL, R_T,  R_T,  K_2,  CHK_NONE};
            6'd3:  u = '{OP_ADD, R_F1, R_U,  R_T,  CHK_NONE};
            6'd4:  u = '{OP_MUL, R_T,  R_X0, K_10, CHK_NONE};
            6'd5:  u = '{OP_ADD, R_F1, R_F1, R_T,  CHK_NONE};
            6'd6:  u = '{OP_SUB, R_F1, R_F1, K_20, CHK_NONE};
            // p(x1) -> f2
            6'd7:  u = '{OP_MUL, R_T,  R_X1, R_X1, CHK_NONE};
            6'd8:  u = '{OP_MUL, R_U,  R_T,  R_X1, CHK_NONE};
            6'd9:  u = '{OP_MUL, R_T,  R_T,  K_2,  CHK_NONE};
            6'd10: u = '{OP_ADD, R_F2, R_U,  R_T,  CHK_NONE};
            6'd11: u = '{OP_MUL, R_T,  R_X1, K_10, CHK_NONE};
            6'd12: u = '{OP_ADD, R_F2, R_F2, R_T,  CHK_NONE};
            6'd13: u = '{OP_SUB, R_F2, R_F2, K_20, CHK_NONE};
            // p(x2) -> f3
            6'd14: u = '{OP_MUL, R_T,  R_X2, R_X2, CHK_NONE};
            6'd15: u = '{OP_MUL, R_U,  R_T,  R_X2, CHK_NONE};
            6'd16: u = '{OP_MUL, R_T,  R_T,  K_2,  CHK_NONE};
            6'd17: u = '{OP_ADD, R_F3, R_U,  R_T,  CHK_NONE};
            6'd18: u = '{OP_MUL, R_T,  R_X2, K_10, CHK_NONE};
            6'd19: u = '{OP_ADD, R_F3, R_F3, R_T,  CHK_NONE};
            6'd20: u = '{OP_SUB, R_F3, R_F3, K_20, CHK_NONE};
            // differences and denominator
            6'd21: u = '{OP_SUB, R_H1, R_X0, R_X2, CHK_NONE};
            6'd22: u = '{OP_SUB, R_H2, R_X1, R_X2, CHK_NONE};
            6'd23: u = '{OP_SUB, R_D1, R_F1, R_F3, CHK_NONE};
            6'd24: u = '{OP_SUB, R_D2, R_F2, R_F3, CHK_NONE};
            6'd25: u = '{OP_MUL, R_T,  R_H1, R_H2, CHK_NONE};
            6'd26: u = '{OP_SUB, R_U,  R_H1, R_H2, CHK_NONE};
            6'd27: u = '{OP_MUL, R_DEN, R_T, R_U,  CHK_DEN};
            // a1
            6'd28: u = '{OP_MUL, R_T,  R_H1, R_H1, CHK_NONE};
            6'd29: u = '{OP_MUL, R_T,  R_D2, R_T,  CHK_NONE};
            6'd30: u = '{OP_MUL, R_U,  R_H2, R_H2, CHK_NONE};
            6'd31: u = '{OP_MUL, R_U,  R_D1, R_U,  CHK_NONE};
            6'd32: u = '{OP_SUB, R_T,  R_T,  R_U,  CHK_NONE};
            6'd33: u = '{OP_DIV, R_A1, R_T,  R_DEN, CHK_NONE};
            // a2
            6'd34: u = '{OP_MUL, R_T,  R_D1, R_H2, CHK_NONE};
            6'd35: u = '{OP_MUL, R_U,  R_D2, R_H1, CHK_NONE};
            6'd36: u = '{OP_SUB, R_T,  R_T,  R_U,  CHK_NONE};
            6'd37: u = '{OP_DIV, R_A2, R_T,  R_DEN, CHK_NONE};
            // discriminant
            6'd38: u = '{OP_MUL, R_T,  R_A1, R_A1, CHK_NONE};
            6'd39: u = '{OP_MUL, R_U,  R_F3, K_4,  CHK_NONE};
            6'd40: u = '{OP_MUL, R_U,  R_U,  R_A2, CHK_NONE};
            6'd41: u = '{OP_SUB, R_T,  R_T,  R_U,  CHK_DISC};
            6'd42: u = '{OP_SQRT, R_U, R_T,  R_T,  CHK_NONE};
            6'd43: u = '{OP_QSEL, R_T, R_A1, R_U,  CHK_Q};
            // new estimate and scaled compare
            6'd44: u = '{OP_MUL, R_U,  R_F3, K_M2, CHK_NONE};
            6'd45: u = '{OP_DIV, R_U,  R_U,  R_T,  CHK_NONE};
            6'd46: u = '{OP_ADD, R_R,  R_X2, R_U,  CHK_RVAL};
            6'd47: u = '{OP_MUL, R_U,  R_R,  K_100, CHK_MVAL};
            6'd48: u = '{OP_MUL, R_T,  R_X2, K_100, CHK_FIN};
            // shift the point window
            6'd49: u = '{OP_MOV, R_X0, R_X1, R_X1, CHK_NONE};
            6'd50: u = '{OP_MOV, R_X1, R_X2, R_X2, CHK_NONE};
            6'd51: u = '{OP_MOV, R_X2, R_R,  R_R,  CHK_NONE};
            default: u = '{OP_MOV, R_T, R_T, R_T, CHK_NONE};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mcrf_alu.sv =====
// Shared Q32.32 arithmetic unit: add, subtract, multiply, divide, square root, select, move.
// Multiply uses one 32x32 product per cycle, divide and root one bit per cycle.
// Depends on mcrf_pkg.
`default_nettype none

module mcrf_alu (
    input  wire                     clk,
    input  wire                     rst_n,
    input  mcrf_pkg::alu_req_t      req,
    input  wire logic signed [63:0] opa,
    input  wire logic signed [63:0] opb,
    output mcrf_pkg::alu_rsp_t      rsp,
    output logic signed [63:0]      result
);

    logic                busy_reg;
    logic                done_reg;
    logic [6:0]          cnt_reg;
    mcrf_pkg::alu_op_t   op_reg;
    logic [63:0]         ma_reg;
    logic [63:0]         mb_reg;
    logic                neg_reg;
    logic [127:0]        acc_reg;
    logic [63:0]         pp_reg;
    logic [1:0]          psh_reg;
    logic [64:0]         rem_reg;
    logic [63:0]         q_reg;
    logic [95:0]         dvd_reg;
    logic                ovf_reg;
    logic signed [63:0]  res_reg;
    logic                fault_reg;

    logic [63:0]  ma_w, mb_w;
    logic         long_op, fin;
    logic signed [63:0] sum_w, dif_w;
    logic         sum_ov, dif_ov;
    logic [31:0]  mx, my;
    logic [63:0]  pp_w;
    logic [127:0] pp_sh;
    logic [64:0]  dtry, strial, stry;
    logic         dge, sge;
    logic [63:0]  mag_w;
    logic         sof_neg, sof_flt;
    logic [63:0]  sof_val;

    assign ma_w = opa[63] ? 64'(-opa) : 64'(opa);
    assign mb_w = opb[63] ? 64'(-opb) : 64'(opb);

    assign sum_w  = opa + opb;
    assign dif_w  = opa - opb;
    assign sum_ov = (opa[63] == opb[63]) && (sum_w[63] != opa[63]);
    assign dif_ov = (opa[63] != opb[63]) && (dif_w[63] != opa[63]);

    assign long_op = (req.op == mcrf_pkg::OP_MUL) || (req.op == mcrf_pkg::OP_SQRT)
                   || ((req.op == mcrf_pkg::OP_DIV) && (opb != '0));

    assign fin = busy_reg &&
                 (((op_reg == mcrf_pkg::OP_MUL) && (cnt_reg == 7'd5))
               || ((op_reg == mcrf_pkg::OP_DIV) && (cnt_reg == 7'd96))
               || ((op_reg == mcrf_pkg::OP_SQRT) && (cnt_reg == 7'd48)));

    // partial product select: cnt bit 0 picks the half of a, bit 1 the half of b
    assign mx   = cnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
    assign my   = cnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp_w = 64'(mx) * 64'(my);

    always_comb
    begin
        case (psh_reg)
            2'd0:    pp_sh = {64'b0, pp_reg};
            2'd1:    pp_sh = {32'b0, pp_reg, 32'b0};
            default: pp_sh = {pp_reg, 64'b0};
        endcase
    end

    assign dtry   = {rem_reg[63:0], dvd_reg[95]};
    assign dge    = dtry >= {1'b0, mb_reg};
    assign stry   = {rem_reg[62:0], dvd_reg[95:94]};
    assign strial = {q_reg[62:0], 2'b01};
    assign sge    = stry >= strial;

    // signed conversion of the magnitude at the end of a multiply or divide
    assign mag_w   = (op_reg == mcrf_pkg::OP_MUL) ? acc_reg[95:32] : q_reg;
    assign sof_neg = neg_reg;
    assign sof_flt = sof_neg ? (mag_w[63] && (mag_w[62:0] != '0)) : mag_w[63];
    assign sof_val = sof_neg ? 64'(-mag_w) : mag_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= '0;
                busy_reg <= long_op;
                done_reg <= !long_op;
            end
            else if (fin)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            ma_reg  <= ma_w;
            mb_reg  <= mb_w;
            neg_reg <= opa[63] ^ opb[63];
            acc_reg <= '0;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            dvd_reg <= (req.op == mcrf_pkg::OP_SQRT) ? {opa, 32'b0} : {ma_w, 32'b0};
            case (req.op)
                mcrf_pkg::OP_ADD:
                begin
                    res_reg   <= sum_w;
                    fault_reg <= sum_ov;
                end
                mcrf_pkg::OP_SUB:
                begin
                    res_reg   <= dif_w;
                    fault_reg <= dif_ov;
                end
                mcrf_pkg::OP_QSEL:
                begin
                    res_reg   <= opa[63] ? dif_w : sum_w;
                    fault_reg <= opa[63] ? dif_ov : sum_ov;
                end
                mcrf_pkg::OP_MOV:
                begin
                    res_reg   <= opa;
                    fault_reg <= 1'b0;
                end
                default:
                begin
                    // divide by zero ends here, long ops overwrite later
                    res_reg   <= '0;
                    fault_reg <= 1'b1;
                end
            endcase
        end
        else if (fin)
        begin
            if (op_reg == mcrf_pkg::OP_SQRT)
            begin
                res_reg   <= q_reg;
                fault_reg <= 1'b0;
            end
            else if ((op_reg == mcrf_pkg::OP_MUL) && (acc_reg[127:96] != '0))
            begin
                res_reg   <= '0;
                fault_reg <= 1'b1;
            end
            else
            begin
                res_reg   <= sof_flt ? 64'sd0 : sof_val;
                fault_reg <= sof_flt || ovf_reg;
            end
        end
        else if (busy_reg)
        begin
            case (op_reg)
                mcrf_pkg::OP_MUL:
                begin
                    if (cnt_reg < 7'd4)
                    begin
                        pp_reg  <= pp_w;
                        psh_reg <= 2'(cnt_reg[0]) + 2'(cnt_reg[1]);
                    end
                    if (cnt_reg != 7'd0)
                    begin
                        acc_reg <= acc_reg + pp_sh;
                    end
                end
                mcrf_pkg::OP_DIV:
                begin
                    if (q_reg[63])
                    begin
                        ovf_reg <= 1'b1;
                    end
                    rem_reg <= dge ? {1'b0, 64'(dtry - {1'b0, mb_reg})} : {1'b0, dtry[63:0]};
                    q_reg   <= {q_reg[62:0], dge};
                    dvd_reg <= {dvd_reg[94:0], 1'b0};
                end
                mcrf_pkg::OP_SQRT:
                begin
                    rem_reg <= sge ? (stry - strial) : stry;
                    q_reg   <= {q_reg[62:0], sge};
                    dvd_reg <= {dvd_reg[93:0], 2'b00};
                end
                default:
                begin
                    q_reg <= q_reg;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.fault = fault_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/muller_cubic_root_finder.sv =====
// Muller root finder for x^3 + 2x^2 + 10x - 20: microcoded sequencer, register
// file and the shared arithmetic unit. Depends on mcrf_pkg and mcrf_alu.
//
//  channel  | direction | handshake            | word
//  item     | in        | item_valid/item_stall | three Q16.16 guesses
//  result   | out       | result_valid/stall   | root, status, iterations
//  cfg      | in        | cfg_valid/cfg_ready  | iteration limit (8 bits)
//
// One item runs 52 micro-ops per parabola step; each passes through the fetch and
// issue states and then waits on the unit. Steps run one after another, up to
// limit+2 steps, after the guesses are loaded and before the word is handed off;
// the three divides take nearly half of each step. item_stall stays high from
// accept until the word lands in the output register. Reset is asynchronous;
// the limit resets to 50.
`default_nettype none

module muller_cubic_root_finder (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  mcrf_pkg::item_t      item_data,
    output logic                 result_valid,
    input  wire                  result_stall,
    output mcrf_pkg::result_t    result_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [7:0]      cfg_data
);

    mcrf_pkg::seq_state_t state_reg, state_next;
    mcrf_pkg::item_t      in_reg;
    mcrf_pkg::result_t    out_reg;
    logic                 out_valid_reg;
    logic [1:0]           load_cnt_reg;
    logic [5:0]           pc_reg;
    logic [8:0]           iter_reg;
    logic [7:0]           limit_reg;
    logic                 fault_acc_reg;
    logic signed [63:0]   m_reg, r_reg, res_reg;
    logic [1:0]           status_reg;
    logic [8:0]           used_reg;

    logic signed [63:0]   rf_mem [16];
    logic signed [63:0]   rd_a_reg, rd_b_reg;

    mcrf_pkg::uop_t       uop;
    mcrf_pkg::alu_req_t   alu_req;
    mcrf_pkg::alu_rsp_t   alu_rsp;
    logic signed [63:0]   alu_res;
    logic signed [63:0]   opa, opb;

    logic                 we;
    logic [3:0]           wa;
    logic signed [63:0]   wd;
    logic signed [63:0]   guess_q;
    logic                 fault_now;
    logic                 finish;
    logic [1:0]           fin_status;
    logic [8:0]           fin_used;
    logic                 out_load;
    logic signed [63:0]   res_sh;
    logic signed [31:0]   root_sat;

    assign uop = mcrf_pkg::ucode(pc_reg);

    assign opa = uop.srca[4] ? mcrf_pkg::const_val(uop.srca) : rd_a_reg;
    assign opb = uop.srcb[4] ? mcrf_pkg::const_val(uop.srcb) : rd_b_reg;

    mcrf_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (opa),
        .opb    (opb),
        .rsp    (alu_rsp),
        .result (alu_res)
    );

    always_comb
    begin
        case (load_cnt_reg)
            2'd0:    guess_q = mcrf_pkg::to_q32(in_reg.first_guess);
            2'd1:    guess_q = mcrf_pkg::to_q32(in_reg.second_guess);
            default: guess_q = mcrf_pkg::to_q32(in_reg.third_guess);
        endcase
    end

    assign we = (state_reg == mcrf_pkg::ST_LOAD)
             || ((state_reg == mcrf_pkg::ST_WAIT) && alu_rsp.done);
    assign wa = (state_reg == mcrf_pkg::ST_LOAD) ? {2'b00, load_cnt_reg} : uop.dst[3:0];
    assign wd = (state_reg == mcrf_pkg::ST_LOAD) ? guess_q : alu_res;

    assign fault_now = fault_acc_reg || alu_rsp.fault;
    assign out_load  = (state_reg == mcrf_pkg::ST_DONE) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        state_next    = state_reg;
        alu_req.start = 1'b0;
        alu_req.op    = uop.op;
        finish        = 1'b0;
        fin_status    = mcrf_pkg::STAT_FAULT;
        fin_used      = iter_reg;
        case (state_reg)
            mcrf_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = mcrf_pkg::ST_LOAD;
                end
            end
            mcrf_pkg::ST_LOAD:
            begin
                if (load_cnt_reg == 2'd2)
                begin
                    state_next = mcrf_pkg::ST_FETCH;
                end
            end
            mcrf_pkg::ST_FETCH:
            begin
                state_next = mcrf_pkg::ST_ISSUE;
            end
            mcrf_pkg::ST_ISSUE:
            begin
                alu_req.start = 1'b1;
                state_next    = mcrf_pkg::ST_WAIT;
            end
            mcrf_pkg::ST_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    case (uop.chk)
                        mcrf_pkg::CHK_DEN,
                        mcrf_pkg::CHK_Q:
                        begin
                            finish = fault_now || (alu_res == '0);
                        end
                        mcrf_pkg::CHK_DISC:
                        begin
                            finish = fault_now || alu_res[63];
                            if (!fault_now)
                            begin
                                fin_status = mcrf_pkg::STAT_DISC;
                            end
                        end
                        mcrf_pkg::CHK_FIN:
                        begin
                            if (fault_now)
                            begin
                                finish = 1'b1;
                            end
                            else if (m_reg[63:32] == alu_res[63:32])
                            begin
                                finish     = 1'b1;
                                fin_status = mcrf_pkg::STAT_CONV;
                                fin_used   = iter_reg + 9'd1;
                            end
                        end
                        default:
                        begin
                            finish = 1'b0;
                        end
                    endcase
                    if (!finish && (pc_reg == mcrf_pkg::LAST_PC)
                        && (iter_reg > {1'b0, limit_reg}))
                    begin
                        finish     = 1'b1;
                        fin_status = mcrf_pkg::STAT_LIMIT;
                        fin_used   = iter_reg + 9'd1;
                    end
                    state_next = finish ? mcrf_pkg::ST_DONE : mcrf_pkg::ST_FETCH;
                end
            end
            mcrf_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = mcrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcrf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            limit_reg     <= mcrf_pkg::LIMIT_RESET;
            load_cnt_reg  <= '0;
            pc_reg        <= '0;
            iter_reg      <= '0;
            fault_acc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                mcrf_pkg::ST_IDLE:
                begin
                    load_cnt_reg  <= '0;
                    pc_reg        <= '0;
                    iter_reg      <= '0;
                    fault_acc_reg <= 1'b0;
                end
                mcrf_pkg::ST_LOAD:
                begin
                    load_cnt_reg <= load_cnt_reg + 2'd1;
                end
                mcrf_pkg::ST_WAIT:
                begin
                    if (alu_rsp.done && !finish)
                    begin
                        if (pc_reg == mcrf_pkg::LAST_PC)
                        begin
                            // next parabola step starts with a clean fault flag
                            pc_reg        <= '0;
                            iter_reg      <= iter_reg + 9'd1;
                            fault_acc_reg <= 1'b0;
                        end
                        else
                        begin
                            pc_reg        <= pc_reg + 6'd1;
                            fault_acc_reg <= fault_now;
                        end
                    end
                end
                default:
                begin
                    pc_reg <= pc_reg;
                end
            endcase
        end
    end

    // register file and payload registers
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[wa] <= wd;
        end
        if (state_reg == mcrf_pkg::ST_FETCH)
        begin
            rd_a_reg <= rf_mem[uop.srca[3:0]];
            rd_b_reg <= rf_mem[uop.srcb[3:0]];
        end
        if (item_valid && !item_stall)
        begin
            in_reg <= item_data;
        end
        if (state_reg == mcrf_pkg::ST_LOAD)
        begin
            res_reg <= mcrf_pkg::to_q32(in_reg.third_guess);
        end
        if ((state_reg == mcrf_pkg::ST_WAIT) && alu_rsp.done)
        begin
            if (uop.chk == mcrf_pkg::CHK_RVAL)
            begin
                r_reg <= alu_res;
            end
            if (uop.chk == mcrf_pkg::CHK_MVAL)
            begin
                m_reg <= alu_res;
            end
            if ((uop.chk == mcrf_pkg::CHK_FIN) && !fault_now)
            begin
                res_reg <= r_reg;
            end
            if (finish)
            begin
                status_reg <= fin_status;
                used_reg   <= fin_used;
            end
        end
        if (out_load)
        begin
            out_reg.root            <= root_sat;
            out_reg.status          <= status_reg;
            out_reg.iterations_used <= used_reg;
        end
    end

    // floor to Q16.16, then clamp to 32 bits
    assign res_sh   = res_reg >>> mcrf_pkg::IN_SHIFT;
    assign root_sat = (res_sh[63:31] == {33{res_sh[31]}}) ? res_sh[31:0]
                    : (res_sh[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign item_stall   = (state_reg != mcrf_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;
    assign cfg_ready    = 1'b1;

    a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == mcrf_pkg::ST_WAIT))
        else $error("arithmetic unit finished outside the wait state");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == mcrf_pkg::ST_LOAD))
        else $error("accepted word did not start the load");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcrf_pkg::ST_WAIT) |-> (iter_reg <= {1'b0, limit_reg} + 9'd1))
        else $error("step counter ran past the limit");

    a_conv_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_data.status == mcrf_pkg::STAT_CONV))
        |-> (result_data.iterations_used != '0))
        else $error("converged word reports zero steps");

endmodule

`default_nettype wire
